// File: design/lsl_pkg.sv
// Shared types and constants for the bounded linked list block.
// No dependencies; used by every module in this folder.
package lsl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   typedef enum logic [2:0] {
      OP_APPEND     = 3'd0,
      OP_PREPEND    = 3'd1,
      OP_INSERT     = 3'd2,
      OP_DEL_FIRST  = 3'd3,
      OP_DEL_LAST   = 3'd4,
      OP_SUM        = 3'd5,
      OP_MAX        = 3'd6,
      OP_SEARCH     = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NOKEY = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_WALK,
      SEQ_SPLICE
   } seq_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_PREPEND,
      CELL_WRITE,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [IDX_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

// File: design/lsl_cell.sv
// One storage cell of the list ring: holds the entry at its list position.
// Depends on lsl_pkg.
module lsl_cell (
   input  logic                              clock,
   input  lsl_pkg::cell_cmd_type             cmd,
   input  logic [lsl_pkg::IDX_W-1:0]         idx,
   input  logic signed [lsl_pkg::DATA_W-1:0] left_value,
   input  logic signed [lsl_pkg::DATA_W-1:0] right_value,
   output logic signed [lsl_pkg::DATA_W-1:0] value
);
   import lsl_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic [IDX_W:0]           slot_after;

   assign slot_after = {1'b0, cmd.pos} + {{IDX_W{1'b0}}, 1'b1};

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         CELL_ROTATE: begin
            value_in = right_value;
         end
         CELL_PREPEND: begin
            value_in = (idx == '0) ? cmd.value : left_value;
         end
         CELL_WRITE: begin
            if (idx == cmd.pos) value_in = cmd.value;
         end
         CELL_INSERT: begin
            if ({1'b0, idx} == slot_after) value_in = cmd.value;
            else if ({1'b0, idx} > slot_after) value_in = left_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: design/lsl_seq.sv
// Sequencer: decodes transactions, drives the cell ring and walks the head cell.
// Depends on lsl_pkg.
module lsl_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_opcode,
   input  logic signed [lsl_pkg::DATA_W-1:0] req_item_value,
   input  logic signed [lsl_pkg::DATA_W-1:0] req_match_key,
   input  logic signed [lsl_pkg::DATA_W-1:0] head_value,
   output lsl_pkg::cell_cmd_type             cell_cmd,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [lsl_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_found,
   output logic [lsl_pkg::CNT_W-1:0]         rsp_entry_count
);
   import lsl_pkg::*;

   seq_state_type            state_ff, state_in;
   op_type                   op_ff, op_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         step_ff, step_in;
   logic signed [DATA_W-1:0] acc_ff, acc_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_result_ff, rsp_result_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic is_full, is_empty, in_range, last_step;

   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign in_range  = ({{(CNT_W-IDX_W){1'b0}}, step_ff} < count_ff);
   assign last_step = (step_ff == IDX_W'(CAPACITY - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) state_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            if ((op_ff == OP_INSERT && !is_full) || op_ff == OP_SUM ||
                op_ff == OP_SEARCH || (op_ff == OP_MAX && !is_empty))
               state_in = SEQ_WALK;
            else
               state_in = SEQ_IDLE;
         end
         SEQ_WALK: begin
            if (last_step)
               state_in = (op_ff == OP_INSERT && hit_in) ? SEQ_SPLICE : SEQ_IDLE;
         end
         SEQ_SPLICE: begin
            state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // outputs to the ring
   always_comb begin
      busy           = (state_ff != SEQ_IDLE);
      cell_cmd.op    = CELL_HOLD;
      cell_cmd.pos   = pos_ff;
      cell_cmd.value = val_ff;
      case (state_ff)
         SEQ_EXEC: begin
            case (op_ff)
               OP_APPEND: begin
                  if (!is_full) begin
                     cell_cmd.op  = CELL_WRITE;
                     cell_cmd.pos = count_ff[IDX_W-1:0];
                  end
               end
               OP_PREPEND: begin
                  if (!is_full) cell_cmd.op = CELL_PREPEND;
               end
               OP_DEL_FIRST: begin
                  if (!is_empty) cell_cmd.op = CELL_ROTATE;
               end
               default: begin
                  cell_cmd.op = CELL_HOLD;
               end
            endcase
         end
         SEQ_WALK: begin
            cell_cmd.op = CELL_ROTATE;
         end
         SEQ_SPLICE: begin
            cell_cmd.op = CELL_INSERT;
         end
         default: begin
            cell_cmd.op = CELL_HOLD;
         end
      endcase
   end

   // datapath
   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      hit_in        = hit_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_result_in = '0;
      rsp_found_in  = 1'b0;
      rsp_count_in  = count_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               op_in  = op_type'(req_opcode);
               val_in = req_item_value;
               key_in = req_match_key;
               step_in = '0;
               acc_in  = '0;
               hit_in  = 1'b0;
               pos_in  = '0;
            end
         end
         SEQ_EXEC: begin
            case (op_ff)
               OP_APPEND, OP_PREPEND: begin
                  rsp_valid_in = 1'b1;
                  if (is_full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     count_in     = count_ff + 1'b1;
                     rsp_count_in = count_ff + 1'b1;
                  end
               end
               OP_INSERT: begin
                  if (is_full) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_FULL;
                  end
               end
               OP_DEL_FIRST, OP_DEL_LAST: begin
                  rsp_valid_in = 1'b1;
                  if (is_empty) begin
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     count_in     = count_ff - 1'b1;
                     rsp_count_in = count_ff - 1'b1;
                  end
               end
               OP_MAX: begin
                  if (is_empty) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_EMPTY;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b0;
               end
            endcase
         end
         SEQ_WALK: begin
            step_in = step_ff + 1'b1;
            if (in_range) begin
               case (op_ff)
                  OP_SUM: begin
                     acc_in = acc_ff + head_value;
                  end
                  OP_MAX: begin
                     if (step_ff == '0 || head_value > acc_ff) acc_in = head_value;
                  end
                  OP_SEARCH: begin
                     if (head_value == val_ff) hit_in = 1'b1;
                  end
                  OP_INSERT: begin
                     if (!hit_ff && head_value == key_ff) begin
                        hit_in = 1'b1;
                        pos_in = step_ff;
                     end
                  end
                  default: begin
                     acc_in = acc_ff;
                  end
               endcase
            end
            if (last_step) begin
               case (op_ff)
                  OP_INSERT: begin
                     if (!hit_in) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_NOKEY;
                     end
                  end
                  OP_SUM, OP_MAX: begin
                     rsp_valid_in  = 1'b1;
                     rsp_result_in = acc_in;
                  end
                  OP_SEARCH: begin
                     rsp_valid_in = 1'b1;
                     rsp_found_in = hit_in;
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
            end
         end
         SEQ_SPLICE: begin
            count_in     = count_ff + 1'b1;
            rsp_count_in = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      key_ff        <= key_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      hit_ff        <= hit_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

// File: design/bounded_singly_linked_list.sv
// Top level of the bounded list: sequencer plus a ring of 64 value cells.
// Depends on lsl_pkg, lsl_cell and lsl_seq.
//
// Entries are held in list order in a ring of cells, position 0 at the head.
// Append, prepend, delete first and delete last finish in the execute state,
// which registers the result strobe. Insert after key, sum, maximum and
// search rotate the whole ring once, one cell per cycle, reading the head
// cell, then register the result; an insert that finds its key first
// splices in the new entry. A full insert and an empty maximum answer from
// the execute state. busy is high from acceptance until the result is
// registered; rsp_valid is high for one cycle and the receiver cannot stall it.
module bounded_singly_linked_list (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_opcode,
   input  logic signed [lsl_pkg::DATA_W-1:0] req_item_value,
   input  logic signed [lsl_pkg::DATA_W-1:0] req_match_key,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [lsl_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_found,
   output logic [lsl_pkg::CNT_W-1:0]         rsp_entry_count
);
   import lsl_pkg::*;

   cell_cmd_type             cell_cmd;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];

   lsl_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_item_value   (req_item_value),
      .req_match_key    (req_match_key),
      .head_value       (cell_value[0]),
      .cell_cmd         (cell_cmd),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_value (rsp_result_value),
      .rsp_found        (rsp_found),
      .rsp_entry_count  (rsp_entry_count)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lsl_cell u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .idx         (IDX_W'(i)),
         .left_value  (cell_value[(i + CAPACITY - 1) % CAPACITY]),
         .right_value (cell_value[(i + 1) % CAPACITY]),
         .value       (cell_value[i])
      );
   end

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after transaction accepted");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_W'(CAPACITY)))
      else $error("entry count beyond capacity");

   a_full_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status_type'(rsp_status) == STATUS_FULL)
         |-> (rsp_entry_count == CNT_W'(CAPACITY)))
      else $error("full status with list not full");

   a_empty_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status_type'(rsp_status) == STATUS_EMPTY)
         |-> (rsp_entry_count == '0 && rsp_result_value == '0))
      else $error("empty status with entries or value");

   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid) || $past(busy))
      else $error("result strobe without a transaction");

endmodule
